// ----- src/rmts_pkg.sv -----
// Shared constants, register codes and result type of the rate-monotonic scheduler.
package rmts_pkg;

	localparam int NUM_TASKS  = 4;
	localparam int TIME_WIDTH = 16;
	localparam int IDX_W      = $clog2(NUM_TASKS);
	localparam int TCOUNT_W   = 3;
	localparam int NOW_W      = 32;
	localparam int TOTAL_W    = 18;
	localparam int WORD_W     = 48;
	localparam int ADDR_W     = 6;
	localparam int DATA_W     = 64;

	localparam logic [TCOUNT_W-1:0] NUM_TASKS_C = TCOUNT_W'(NUM_TASKS);
	localparam logic [2:0]          IDLE_MARK   = 3'd7;
	localparam logic [TOTAL_W-1:0]  TOTAL_SAT   = {TOTAL_W{1'b1}};

	// Register codes, taken from paddr[5:3]
	typedef enum logic [2:0] {
		REG_TASK_COUNT  = 3'd0,
		REG_TASK_WORD_0 = 3'd1,
		REG_TASK_WORD_1 = 3'd2,
		REG_TASK_WORD_2 = 3'd3,
		REG_TASK_WORD_3 = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [NOW_W-1:0]     now;
		logic                 cpu_busy;
		logic [IDX_W-1:0]     running_task;
		logic                 fresh_start;
		logic                 preempted;
		logic                 job_finished;
		logic [NUM_TASKS-1:0] missed_mask;
		logic [TOTAL_W-1:0]   miss_total;
		logic [TOTAL_W-1:0]   done_total;
		logic                 all_done;
	} result_t;

endpackage

// ----- src/rmts_tick_if.sv -----
// Tick channel: valid/ready handshake carrying the restart flag.
interface rmts_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

// ----- src/rmts_result_if.sv -----
// Result channel: valid/ready handshake carrying one scheduler result item.
interface rmts_result_if;
	import rmts_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [NOW_W-1:0]     now;
	logic                 cpu_busy;
	logic [IDX_W-1:0]     running_task;
	logic                 fresh_start;
	logic                 preempted;
	logic                 job_finished;
	logic [NUM_TASKS-1:0] missed_mask;
	logic [TOTAL_W-1:0]   miss_total;
	logic [TOTAL_W-1:0]   done_total;
	logic                 all_done;

	modport source (
		output valid, output now, output cpu_busy, output running_task,
		output fresh_start, output preempted, output job_finished,
		output missed_mask, output miss_total, output done_total, output all_done,
		input ready
	);
	modport sink (
		input valid, input now, input cpu_busy, input running_task,
		input fresh_start, input preempted, input job_finished,
		input missed_mask, input miss_total, input done_total, input all_done,
		output ready
	);
endinterface

// ----- src/rate_monotonic_task_scheduler.sv -----
// Preemptive rate-monotonic scheduler: one tick in, one result out per unstalled cycle.
//
// Each tick item advances the schedule by one time unit (or, with restart set, reloads all
// per-task state from the task words at time zero). On a tick every active task whose phase
// counter is at zero releases a job if repeats remain; a task whose previous job is still
// pending misses its deadline instead, restarts the job and spends a repeat. The pending
// task with the shortest period (zero counts as one, ties to the lowest index) then runs
// one unit. Once every active task has used its repeats, ticks change nothing and report
// idle with all_done set. Throughput is one item per clock while the skid is free: the
// release, the four-way priority scan and the counter updates are a single combinational
// pass from the task state registers into the result registers. A two-entry result buffer
// (main register plus skid) lets the block keep taking items while a result is stalled;
// ready drops only when both entries hold results. Configuration uses an APB port with
// 64-bit data: task_count at byte 0x00, task words 0..3 at 0x08, 0x10, 0x18, 0x20. Period
// and execution-time changes take effect immediately; per-task counters reload only on a
// restart item. No clearing pass is needed after reset.
module rate_monotonic_task_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	rmts_tick_if.sink                   tick,
	rmts_result_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rmts_pkg::ADDR_W-1:0] paddr,
	input  logic [rmts_pkg::DATA_W-1:0] pwdata,
	output logic [rmts_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import rmts_pkg::*;

	// Configuration registers
	logic [TCOUNT_W-1:0] task_count_q;
	logic [WORD_W-1:0]   task_word_q [NUM_TASKS];

	// Per-task scheduler state
	logic [TIME_WIDTH-1:0] time_left_q    [NUM_TASKS];
	logic [TIME_WIDTH-1:0] phase_count_q  [NUM_TASKS];
	logic [TIME_WIDTH-1:0] repeats_left_q [NUM_TASKS];
	logic [NUM_TASKS-1:0]  job_pending_q;
	logic [2:0]            last_runner_q;
	logic [NOW_W-1:0]      tick_count_q;
	logic [TOTAL_W-1:0]    miss_counter_q;
	logic [TOTAL_W-1:0]    done_counter_q;

	// Result buffer
	result_t main_q, skid_q;
	logic    main_valid_q, skid_valid_q;

	// Next-state values
	logic [TIME_WIDTH-1:0] time_left_d    [NUM_TASKS];
	logic [TIME_WIDTH-1:0] phase_count_d  [NUM_TASKS];
	logic [TIME_WIDTH-1:0] repeats_left_d [NUM_TASKS];
	logic [NUM_TASKS-1:0]  job_pending_d;
	logic [2:0]            last_runner_d;
	logic [NOW_W-1:0]      tick_count_d;
	logic [TOTAL_W-1:0]    miss_counter_d;
	logic [TOTAL_W-1:0]    done_counter_d;
	result_t               res_d;

	// Per-lane work signals
	logic [TCOUNT_W-1:0]   n_act;
	logic [NUM_TASKS-1:0]  act, reps_nz, rel, miss, pend1, elig, is_best, fin_lane;
	logic [NUM_TASKS-1:0]  reps2_nz, reps_cfg_nz;
	logic [TIME_WIDTH-1:0] exec_t  [NUM_TASKS];
	logic [TIME_WIDTH-1:0] reps_t  [NUM_TASKS];
	logic [TIME_WIDTH-1:0] per_t   [NUM_TASKS];
	logic [TIME_WIDTH-1:0] tl1     [NUM_TASKS];
	logic [TIME_WIDTH-1:0] reps1   [NUM_TASKS];
	logic [TIME_WIDTH-1:0] tl2     [NUM_TASKS];
	logic [TIME_WIDTH-1:0] reps2   [NUM_TASKS];
	logic [TIME_WIDTH:0]   phase_nx [NUM_TASKS];
	logic                  done_pre, best_valid, fresh, fin, pre;
	logic [IDX_W-1:0]      best_idx;
	logic [TIME_WIDTH-1:0] best_per;
	logic [2:0]            miss_n;
	logic [TOTAL_W:0]      miss_sum, done_sum;

	logic tick_acc, res_take, cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign tick.ready = ~skid_valid_q;
	assign tick_acc = tick.valid & tick.ready;
	assign res_take = main_valid_q & result.ready;

	// Configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				task_word_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[5:3]))
				REG_TASK_COUNT:  task_count_q   <= pwdata[TCOUNT_W-1:0];
				REG_TASK_WORD_0: task_word_q[0] <= pwdata[WORD_W-1:0];
				REG_TASK_WORD_1: task_word_q[1] <= pwdata[WORD_W-1:0];
				REG_TASK_WORD_2: task_word_q[2] <= pwdata[WORD_W-1:0];
				REG_TASK_WORD_3: task_word_q[3] <= pwdata[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	// Configuration read
	always_comb begin
		case (reg_idx_t'(paddr[5:3]))
			REG_TASK_COUNT:  prdata = DATA_W'(task_count_q);
			REG_TASK_WORD_0: prdata = DATA_W'(task_word_q[0]);
			REG_TASK_WORD_1: prdata = DATA_W'(task_word_q[1]);
			REG_TASK_WORD_2: prdata = DATA_W'(task_word_q[2]);
			REG_TASK_WORD_3: prdata = DATA_W'(task_word_q[3]);
			default:         prdata = '0;
		endcase
	end

	// One scheduling pass
	always_comb begin
		n_act = (task_count_q > NUM_TASKS_C) ? NUM_TASKS_C : task_count_q;

		// Decode task words, then release jobs and flag misses
		for (int i = 0; i < NUM_TASKS; i++) begin
			act[i]         = TCOUNT_W'(i) < n_act;
			exec_t[i]      = task_word_q[i][16 +: TIME_WIDTH];
			reps_t[i]      = task_word_q[i][32 +: TIME_WIDTH];
			per_t[i]       = (task_word_q[i][TIME_WIDTH-1:0] == '0) ?
			                 TIME_WIDTH'(1) : task_word_q[i][TIME_WIDTH-1:0];
			reps_nz[i]     = repeats_left_q[i] != '0;
			reps_cfg_nz[i] = reps_t[i] != '0;
			rel[i]         = act[i] && phase_count_q[i] == '0 && reps_nz[i];
			miss[i]        = rel[i] & job_pending_q[i];
			tl1[i]         = miss[i] ? exec_t[i] : time_left_q[i];
			reps1[i]       = miss[i] ? repeats_left_q[i] - 1'b1 : repeats_left_q[i];
			// A miss that spends the last repeat drops the job
			pend1[i]       = miss[i] ? (reps1[i] != '0) : (rel[i] | job_pending_q[i]);
			elig[i]        = act[i] & pend1[i] & (reps1[i] != '0);
		end
		done_pre = ~|(act & reps_nz);

		// Priority scan: shortest period wins, ties keep the lower index
		best_valid = 1'b0;
		best_idx   = '0;
		best_per   = '0;
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (elig[i] && (!best_valid || per_t[i] < best_per)) begin
				best_valid = 1'b1;
				best_idx   = IDX_W'(i);
				best_per   = per_t[i];
			end
		end

		// Run the winner one unit, advance phases
		fresh = 1'b0;
		fin   = 1'b0;
		pre   = 1'b0;
		for (int i = 0; i < NUM_TASKS; i++) begin
			is_best[i]  = best_valid && best_idx == IDX_W'(i);
			fin_lane[i] = is_best[i] && tl1[i] <= TIME_WIDTH'(1);
			tl2[i]      = is_best[i] ? (fin_lane[i] ? exec_t[i] : tl1[i] - 1'b1) : tl1[i];
			reps2[i]    = fin_lane[i] ? reps1[i] - 1'b1 : reps1[i];
			reps2_nz[i] = reps2[i] != '0;
			phase_nx[i] = {1'b0, phase_count_q[i]} + 1'b1;
			fresh       = fresh | (is_best[i] && tl1[i] == exec_t[i]);
			fin         = fin | fin_lane[i];
			pre         = pre | (last_runner_q == 3'(i) && pend1[i]);
		end
		pre = pre && last_runner_q < n_act &&
		      (!best_valid || last_runner_q[IDX_W-1:0] != best_idx);

		miss_n   = 3'($countones(miss));
		miss_sum = {1'b0, miss_counter_q} + (TOTAL_W+1)'(miss_n);
		done_sum = {1'b0, done_counter_q} + (TOTAL_W+1)'(fin);

		// Hold state by default
		time_left_d    = time_left_q;
		phase_count_d  = phase_count_q;
		repeats_left_d = repeats_left_q;
		job_pending_d  = job_pending_q;
		last_runner_d  = last_runner_q;
		tick_count_d   = tick_count_q;
		miss_counter_d = miss_counter_q;
		done_counter_d = done_counter_q;

		res_d              = '0;
		res_d.now          = tick_count_q;
		res_d.miss_total   = miss_counter_q;
		res_d.done_total   = done_counter_q;
		res_d.all_done     = 1'b1;

		if (tick.restart) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				time_left_d[i]    = exec_t[i];
				phase_count_d[i]  = '0;
				repeats_left_d[i] = reps_t[i];
			end
			job_pending_d  = '0;
			last_runner_d  = IDLE_MARK;
			tick_count_d   = '0;
			miss_counter_d = '0;
			done_counter_d = '0;
			res_d.now        = '0;
			res_d.miss_total = '0;
			res_d.done_total = '0;
			res_d.all_done   = ~|(act & reps_cfg_nz);
		end else if (!done_pre) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				time_left_d[i]    = tl2[i];
				repeats_left_d[i] = reps2[i];
				job_pending_d[i]  = pend1[i] & ~fin_lane[i];
				phase_count_d[i]  = (phase_nx[i] >= {1'b0, per_t[i]}) ?
				                    '0 : phase_nx[i][TIME_WIDTH-1:0];
			end
			last_runner_d  = (best_valid && !fin) ? {1'b0, best_idx} : IDLE_MARK;
			tick_count_d   = tick_count_q + 1'b1;
			miss_counter_d = miss_sum[TOTAL_W] ? TOTAL_SAT : miss_sum[TOTAL_W-1:0];
			done_counter_d = done_sum[TOTAL_W] ? TOTAL_SAT : done_sum[TOTAL_W-1:0];

			res_d.cpu_busy     = best_valid;
			res_d.running_task = best_valid ? best_idx : '0;
			res_d.fresh_start  = fresh;
			res_d.preempted    = pre;
			res_d.job_finished = fin;
			res_d.missed_mask  = miss;
			res_d.miss_total   = miss_counter_d;
			res_d.done_total   = done_counter_d;
			res_d.all_done     = ~|(act & reps2_nz);
		end
	end

	// Commit state on an accepted tick item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				time_left_q[i]    <= '0;
				phase_count_q[i]  <= '0;
				repeats_left_q[i] <= '0;
			end
			job_pending_q  <= '0;
			last_runner_q  <= IDLE_MARK;
			tick_count_q   <= '0;
			miss_counter_q <= '0;
			done_counter_q <= '0;
		end else if (tick_acc) begin
			time_left_q    <= time_left_d;
			phase_count_q  <= phase_count_d;
			repeats_left_q <= repeats_left_d;
			job_pending_q  <= job_pending_d;
			last_runner_q  <= last_runner_d;
			tick_count_q   <= tick_count_d;
			miss_counter_q <= miss_counter_d;
			done_counter_q <= done_counter_d;
		end
	end

	// Result buffer: main register feeds the port, skid holds the newer item under stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || res_take) begin
			main_valid_q <= skid_valid_q | tick_acc;
			skid_valid_q <= skid_valid_q & tick_acc;
		end else if (tick_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || res_take) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				if (tick_acc) begin
					skid_q <= res_d;
				end
			end else if (tick_acc) begin
				main_q <= res_d;
			end
		end else if (tick_acc) begin
			skid_q <= res_d;
		end
	end

	assign result.valid        = main_valid_q;
	assign result.now          = main_q.now;
	assign result.cpu_busy     = main_q.cpu_busy;
	assign result.running_task = main_q.running_task;
	assign result.fresh_start  = main_q.fresh_start;
	assign result.preempted    = main_q.preempted;
	assign result.job_finished = main_q.job_finished;
	assign result.missed_mask  = main_q.missed_mask;
	assign result.miss_total   = main_q.miss_total;
	assign result.done_total   = main_q.done_total;
	assign result.all_done     = main_q.all_done;

endmodule
